// File: rtl/cli_pkg.sv
package cli_pkg;

    // Table geometry and field widths.
    localparam int NUM_POINTS = 8;
    localparam int FREQ_BITS  = 30;
    localparam int IDX_W      = 3;
    localparam int PARAM_W    = 8;

    // Scaled differences: a frequency difference divided by ten.
    localparam int DIFF_W     = FREQ_BITS + 1;
    localparam int RECIP_W    = 32;
    localparam int RECIP_SH   = 35;
    localparam logic [RECIP_W-1:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int MUL_W      = FREQ_BITS + RECIP_W;
    localparam int DEN_W      = MUL_W - RECIP_SH;
    localparam int NUM_W      = DEN_W + 1;

    // Product of the parameter span and the scaled numerator.
    localparam int DP_W       = PARAM_W + 1;
    localparam int PROD_W     = NUM_W + DP_W;

    // Pipelined divider: dividend is the product magnitude times four.
    localparam int DVD_W      = PROD_W + 1;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (DVD_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int RET_W      = DVD_W + 1;

    // Output saturation.
    localparam int SAT_LIMIT  = 1020;
    localparam logic [PARAM_W-1:0] PARAM_MAX = 8'hFF;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Values that ride alongside the divider.
    typedef struct packed {
        logic [PARAM_W-1:0] p_lo;
        logic               fault;
        logic               neg;
    } t_side;

endpackage

// File: rtl/calibration_linear_interpolator_unit.sv
// Piecewise linear calibration interpolator.
// Input channel (i_valid, o_stall): one transfer carries either a table write
// (i_req_type low: i_entry_index, i_entry_freq, i_entry_param) or a query
// (i_req_type high: i_query_freq). A write updates the table at its transfer
// and yields no result; a query yields one result transfer on the output
// channel (o_valid, i_stall) with o_interp_value and o_div_fault.
// A query passes the front stages, the divider stages and the output registers
// before o_valid rises. The datapath is a 28-stage pipeline whose depth is set
// by the 38-bit signed division, done as a restoring divider at two quotient
// bits per stage; one item may enter in every cycle while o_stall is low, so
// sustained throughput is one item per cycle when the receiver does not stall.
// Results leave in query order. When the receiver holds i_stall while o_valid
// is high, the whole pipeline freezes and o_stall is raised; nothing is lost
// or repeated. Reset empties the pipeline; the table is not cleared, and a
// query that uses an entry never written returns an undefined value.
module calibration_linear_interpolator_unit
    import cli_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_req_type,
    input  logic [IDX_W-1:0]     i_entry_index,
    input  logic [FREQ_BITS-1:0] i_entry_freq,
    input  logic [PARAM_W-1:0]   i_entry_param,
    input  logic [FREQ_BITS-1:0] i_query_freq,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PARAM_W-1:0]   o_interp_value,
    output logic                 o_div_fault
);

    logic en;
    logic in_xfer;

    // Calibration table.
    logic [FREQ_BITS-1:0] r_freq [NUM_POINTS];
    logic [PARAM_W-1:0]   r_par  [NUM_POINTS];

    // Pipeline registers.
    logic                        r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_vt, r_vo;
    logic [FREQ_BITS-1:0]        r_q1, r_q2;
    logic [FREQ_BITS-1:0]        r_flo2, r_fhi2;
    logic [PARAM_W-1:0]          r_plo2, r_phi2;
    logic signed [DIFF_W-1:0]    r_dq3, r_df3;
    logic [PARAM_W-1:0]          r_plo3, r_phi3, r_plo4, r_plo5, r_plo6, r_plo7, r_plot;
    logic [FREQ_BITS-1:0]        r_mn4, r_md4;
    logic                        r_sn4, r_sd4, r_sn5, r_sd5, r_sd6, r_sd7;
    logic signed [DP_W-1:0]      r_dp4, r_dp5, r_dp6;
    logic [MUL_W-1:0]            r_pn5, r_pd5;
    logic signed [NUM_W-1:0]     r_num6;
    logic [DEN_W-1:0]            r_dm6, r_dm7;
    logic                        r_f6, r_f7, r_ft;
    logic signed [PROD_W-1:0]    r_prod7;
    logic signed [DVD_W-1:0]     r_tmp;
    logic [PARAM_W-1:0]          r_val;
    logic                        r_fo;

    logic [IDX_W-1:0]            n_seg2;
    logic [IDX_W-1:0]            hi_idx;
    logic signed [DIFF_W-1:0]    n_dq3, n_df3;
    logic [DIFF_W-1:0]           n_mn4, n_md4;
    logic [DEN_W-1:0]            qn6;
    logic signed [NUM_W-1:0]     n_num6;
    logic [PROD_W-1:0]           pmag;
    logic [DVD_W-1:0]            dvd8;
    t_side                       side8, side_o;
    logic                        dv_valid;
    logic [DVD_W-1:0]            dv_quo;
    logic signed [DVD_W-1:0]     n_tmp;
    logic signed [RET_W-1:0]     ret;
    logic [PARAM_W-1:0]          n_val;

    // Global advance: hold everything while a result waits on a stalled receiver.
    assign en      = !(r_vo && i_stall);
    assign o_stall = !en;
    assign in_xfer = i_valid && en;

    // Table writes take effect at the transfer itself.
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_req_type == REQ_WRITE && int'(i_entry_index) < NUM_POINTS) begin
            r_freq[i_entry_index] <= i_entry_freq;
            r_par[i_entry_index]  <= i_entry_param;
        end
    end

    // Segment search: the highest inner point not above the query.
    always_comb begin
        n_seg2 = '0;
        for (int s = 1; s <= NUM_POINTS - 2; s++) begin
            if (r_q1 >= r_freq[s]) begin
                n_seg2 = IDX_W'(s);
            end
        end
    end

    // Both segment points are captured together, before any later write lands.
    assign hi_idx = n_seg2 + IDX_W'(1);

    // Signed differences against the lower point.
    assign n_dq3  = $signed({1'b0, r_q2}) - $signed({1'b0, r_flo2});
    assign n_df3  = $signed({1'b0, r_fhi2}) - $signed({1'b0, r_flo2});

    // Magnitudes ahead of the divide-by-ten multiply.
    assign n_mn4 = r_dq3[DIFF_W-1] ? DIFF_W'(-r_dq3) : DIFF_W'(r_dq3);
    assign n_md4 = r_df3[DIFF_W-1] ? DIFF_W'(-r_df3) : DIFF_W'(r_df3);

    // Quotient by ten, sign restored so that it truncates toward zero.
    assign qn6    = r_pn5[MUL_W-1:RECIP_SH];
    assign n_num6 = r_sn5 ? -$signed({1'b0, qn6}) : $signed({1'b0, qn6});

    // Divider operands: product magnitude times four, and the quotient sign.
    assign pmag        = r_prod7[PROD_W-1] ? PROD_W'(-r_prod7) : PROD_W'(r_prod7);
    assign dvd8        = {pmag[PROD_W-3:0], 2'b00, 1'b0} >> 1;
    assign side8.p_lo  = r_plo7;
    assign side8.fault = r_f7;
    assign side8.neg   = r_prod7[PROD_W-1] ^ r_sd7;

    cli_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v7),
        .i_dvd   (dvd8),
        .i_dvs   (r_dm7),
        .i_side  (side8),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (side_o)
    );

    assign n_tmp = side_o.neg ? -$signed(dv_quo) : $signed(dv_quo);

    // Offset, saturate and round to the output range; a fault returns p_lo.
    assign ret = $signed({r_tmp[DVD_W-1], r_tmp})
               + $signed(RET_W'({r_plot, 2'b00}));
    always_comb begin
        if (r_ft) begin
            n_val = r_plot;
        end else if (ret >= $signed(RET_W'(SAT_LIMIT))) begin
            n_val = PARAM_MAX;
        end else if (ret < $signed(RET_W'(0))) begin
            n_val = '0;
        end else begin
            n_val = ret[PARAM_W+1:2] + PARAM_W'(r_tmp[1]);
        end
    end

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_vt <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= in_xfer && i_req_type == REQ_QUERY;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_vt <= dv_valid;
            r_vo <= r_vt;
        end
    end

    // Payload of the pipeline.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1    <= i_query_freq;
            r_q2    <= r_q1;
            r_flo2  <= r_freq[n_seg2];
            r_fhi2  <= r_freq[hi_idx];
            r_plo2  <= r_par[n_seg2];
            r_phi2  <= r_par[hi_idx];
            r_dq3   <= n_dq3;
            r_df3   <= n_df3;
            r_plo3  <= r_plo2;
            r_phi3  <= r_phi2;
            r_mn4   <= n_mn4[FREQ_BITS-1:0];
            r_md4   <= n_md4[FREQ_BITS-1:0];
            r_sn4   <= r_dq3[DIFF_W-1];
            r_sd4   <= r_df3[DIFF_W-1];
            r_dp4   <= $signed({1'b0, r_phi3}) - $signed({1'b0, r_plo3});
            r_plo4  <= r_plo3;
            r_pn5   <= MUL_W'(r_mn4) * MUL_W'(RECIP10);
            r_pd5   <= MUL_W'(r_md4) * MUL_W'(RECIP10);
            r_sn5   <= r_sn4;
            r_sd5   <= r_sd4;
            r_dp5   <= r_dp4;
            r_plo5  <= r_plo4;
            r_num6  <= n_num6;
            r_dm6   <= r_pd5[MUL_W-1:RECIP_SH];
            r_f6    <= r_pd5[MUL_W-1:RECIP_SH] == '0;
            r_sd6   <= r_sd5;
            r_dp6   <= r_dp5;
            r_plo6  <= r_plo5;
            r_prod7 <= PROD_W'(r_dp6) * PROD_W'(r_num6);
            r_dm7   <= r_dm6;
            r_sd7   <= r_sd6;
            r_f7    <= r_f6;
            r_plo7  <= r_plo6;
            r_tmp   <= n_tmp;
            r_plot  <= side_o.p_lo;
            r_ft    <= side_o.fault;
            r_val   <= n_val;
            r_fo    <= r_ft;
        end
    end

    assign o_valid        = r_vo;
    assign o_interp_value = r_val;
    assign o_div_fault    = r_fo;

`ifndef SYNTHESIS
    // A table write never starts a result.
    a_write_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_req_type == REQ_WRITE) |=> !r_v1)
        else $error("table write entered the pipeline");

    // A stalled output freezes the early stages.
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && i_stall) |=> ($stable(r_v1) && $stable(r_v2) && $stable(r_v7)))
        else $error("pipeline moved during a stall");

    // No result straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");
`endif

endmodule

// File: rtl/cli_div_pipe.sv
module cli_div_pipe
    import cli_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DEN_W-1:0] i_dvs,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [DVD_W-1:0] o_quo,
    output t_side            o_side
);

    // Stage registers: remainder, combined dividend and quotient shift word.
    logic             r_v   [DIV_STAGES];
    logic [DEN_W-1:0] r_rem [DIV_STAGES];
    logic [DVD_W-1:0] r_dq  [DIV_STAGES];
    logic [DEN_W-1:0] r_d   [DIV_STAGES];
    t_side            r_sd  [DIV_STAGES];

    logic [DEN_W-1:0] n_rem [DIV_STAGES];
    logic [DVD_W-1:0] n_dq  [DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_stg
            logic [DEN_W-1:0] s_rem;
            logic [DVD_W-1:0] s_dq;
            logic [DEN_W-1:0] s_d;
            logic             s_v;
            t_side            s_sd;

            if (g == 0) begin : g_src_in
                assign s_rem = '0;
                assign s_dq  = i_dvd;
                assign s_d   = i_dvs;
                assign s_v   = i_valid;
                assign s_sd  = i_side;
            end else begin : g_src_reg
                assign s_rem = r_rem[g-1];
                assign s_dq  = r_dq[g-1];
                assign s_d   = r_d[g-1];
                assign s_v   = r_v[g-1];
                assign s_sd  = r_sd[g-1];
            end

            // Two restoring steps per stage, most significant bit first.
            always_comb begin
                logic [DEN_W:0]   trial;
                logic [DEN_W-1:0] rem;
                logic [DVD_W-1:0] dq;
                rem = s_rem;
                dq  = s_dq;
                for (int k = 0; k < DIV_STEPS; k++) begin
                    trial = {rem, dq[DVD_W-1]};
                    dq    = {dq[DVD_W-2:0], 1'b0};
                    if (trial >= {1'b0, s_d}) begin
                        trial = trial - {1'b0, s_d};
                        dq[0] = 1'b1;
                    end
                    rem = trial[DEN_W-1:0];
                end
                n_rem[g] = rem;
                n_dq[g]  = dq;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g] <= 1'b0;
                end else if (i_en) begin
                    r_v[g] <= s_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem[g];
                    r_dq[g]  <= n_dq[g];
                    r_d[g]   <= s_d;
                    r_sd[g]  <= s_sd;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quo   = r_dq[DIV_STAGES-1];
    assign o_side  = r_sd[DIV_STAGES-1];

endmodule

// File: tb/tb_calibration_linear_interpolator_unit.sv
module tb_calibration_linear_interpolator_unit;
    import cli_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_req_type;
    logic [IDX_W-1:0]     i_entry_index;
    logic [FREQ_BITS-1:0] i_entry_freq;
    logic [PARAM_W-1:0]   i_entry_param;
    logic [FREQ_BITS-1:0] i_query_freq;
    logic                 o_valid;
    logic                 i_stall;
    logic [PARAM_W-1:0]   o_interp_value;
    logic                 o_div_fault;

    typedef struct packed {
        logic [PARAM_W-1:0] value;
        logic               fault;
    } t_interp;

    // Predictor copy of the calibration table and the pending results.
    logic [FREQ_BITS-1:0] cal_freq [NUM_POINTS];
    logic [PARAM_W-1:0]   cal_param [NUM_POINTS];
    t_interp              pending_interp [$];
    int                   error_count;
    int                   stall_mode;
    int                   gap_mode;

    calibration_linear_interpolator_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_entry_index  (i_entry_index),
        .i_entry_freq   (i_entry_freq),
        .i_entry_param  (i_entry_param),
        .i_query_freq   (i_query_freq),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_interp_value (o_interp_value),
        .o_div_fault    (o_div_fault)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Interpolates over the segment that the query frequency falls in.
    function automatic t_interp interpolate_point(input logic [FREQ_BITS-1:0] q);
        t_interp r;
        int      s;
        longint  f_lo, f_hi, p_lo, p_hi, num, den, tmp, ret;
        s = NUM_POINTS - 2;
        while (s > 0 && q < cal_freq[s])
            s--;
        f_lo = cal_freq[s];
        f_hi = cal_freq[s+1];
        p_lo = cal_param[s];
        p_hi = cal_param[s+1];
        num = (longint'(q) - f_lo) / 10;
        den = (f_hi - f_lo) / 10;
        r.fault = 1'b0;
        if (den == 0) begin
            r.value = p_lo[PARAM_W-1:0];
            r.fault = 1'b1;
        end else begin
            tmp = ((p_hi - p_lo) * num * 4) / den;
            ret = tmp + p_lo * 4;
            if (ret >= SAT_LIMIT)
                r.value = PARAM_MAX;
            else if (ret < 0)
                r.value = '0;
            else begin
                ret = ret / 4 + (tmp[1] ? 1 : 0);
                r.value = ret[PARAM_W-1:0];
            end
        end
        return r;
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int pick_gap();
        if (gap_mode == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(8, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Receiver stall, driven at the falling edge.
    always @(negedge i_clk) begin
        if (stall_mode == 0)
            i_stall <= 1'b0;
        else if (i_stall)
            i_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ($urandom_range(0, 30) == 0);
        else
            i_stall <= ($urandom_range(0, 3) == 0);
    end

    // Result checking at each output transfer.
    always @(posedge i_clk) begin
        t_interp exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_interp.size() == 0) begin
                $error("unexpected result value=%0d fault=%0b", o_interp_value, o_div_fault);
                error_count++;
            end else begin
                exp_r = pending_interp.pop_front();
                if (o_interp_value !== exp_r.value) begin
                    $error("interp_value expected %0d actual %0d", exp_r.value,
                           o_interp_value);
                    error_count++;
                end
                if (o_div_fault !== exp_r.fault) begin
                    $error("div_fault expected %0b actual %0b", exp_r.fault, o_div_fault);
                    error_count++;
                end
            end
        end
    end

    // Sends one item and updates the prediction at its transfer.
    task automatic send_item(input logic req, input logic [IDX_W-1:0] idx,
                             input logic [FREQ_BITS-1:0] ef,
                             input logic [PARAM_W-1:0] ep,
                             input logic [FREQ_BITS-1:0] qf);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_entry_index <= idx;
        i_entry_freq  <= ef;
        i_entry_param <= ep;
        i_query_freq  <= qf;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (req == REQ_WRITE) begin
            cal_freq[idx]  = ef;
            cal_param[idx] = ep;
        end else begin
            pending_interp.push_back(interpolate_point(qf));
        end
    endtask

    task automatic write_point(input int idx, input logic [FREQ_BITS-1:0] f,
                               input logic [PARAM_W-1:0] p);
        send_item(REQ_WRITE, idx[IDX_W-1:0], f, p, FREQ_BITS'($urandom));
    endtask

    task automatic query_at(input logic [FREQ_BITS-1:0] q);
        send_item(REQ_QUERY, IDX_W'($urandom), FREQ_BITS'($urandom),
                  PARAM_W'($urandom), q);
    endtask

    // Loads an ascending table with random spacing; small steps give zero spans.
    task automatic load_sorted_table();
        logic [FREQ_BITS-1:0] f;
        f = FREQ_BITS'($urandom_range(0, 1 << 28));
        for (int i = 0; i < NUM_POINTS; i++) begin
            write_point(i, f, PARAM_W'($urandom));
            if ($urandom_range(0, 9) == 0)
                f = f + FREQ_BITS'($urandom_range(0, 15));
            else
                f = f + FREQ_BITS'($urandom_range(20, 1 << 26));
        end
    endtask

    // Directed: full-scale extremes, exact breakpoints, both ends extrapolated.
    task automatic test_extremes();
        for (int i = 0; i < NUM_POINTS; i++)
            write_point(i, FREQ_BITS'(1000 + i * 100000), (i % 2) ? 8'hFF : 8'h00);
        query_at('0);
        query_at('1);
        query_at(FREQ_BITS'(1000 + 3 * 100000));
        query_at(FREQ_BITS'(1000 + 3 * 100000 + 50000));
        query_at(FREQ_BITS'(1000 + 7 * 100000 + 7));
        query_at(FREQ_BITS'(1000 + 150));
    endtask

    // Directed: zero span segments and out-of-order breakpoints.
    task automatic test_zero_span();
        write_point(0, FREQ_BITS'(500), 8'd40);
        write_point(1, FREQ_BITS'(505), 8'd200);
        write_point(2, FREQ_BITS'(2000), 8'd17);
        write_point(3, FREQ_BITS'(2000), 8'd99);
        write_point(4, FREQ_BITS'(1073741823), 8'd255);
        write_point(5, FREQ_BITS'(9000), 8'd3);
        write_point(6, FREQ_BITS'(8000), 8'd128);
        write_point(7, FREQ_BITS'(0), 8'd1);
        query_at(FREQ_BITS'(500));
        query_at(FREQ_BITS'(2000));
        query_at(FREQ_BITS'(1073741823));
        query_at(FREQ_BITS'(8500));
        query_at(FREQ_BITS'(0));
    endtask

    // Random: mostly sorted tables with queries in range, some noise.
    task automatic test_random(input int n_items);
        int sent;
        int nq;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                for (int i = 0; i < NUM_POINTS; i++)
                    write_point(i, FREQ_BITS'($urandom), PARAM_W'($urandom));
            end else begin
                load_sorted_table();
            end
            sent += NUM_POINTS;
            nq = $urandom_range(3, 20);
            for (int k = 0; k < nq; k++) begin
                case ($urandom_range(0, 5))
                    0: query_at(FREQ_BITS'($urandom));
                    1: query_at(cal_freq[$urandom_range(0, NUM_POINTS - 1)]);
                    default: query_at(FREQ_BITS'(cal_freq[0] - 2000
                                      + FREQ_BITS'($urandom_range(0,
                                      cal_freq[NUM_POINTS-1] - cal_freq[0] + 4000))));
                endcase
                if ($urandom_range(0, 9) == 0)
                    write_point($urandom_range(0, NUM_POINTS - 1), FREQ_BITS'($urandom),
                                PARAM_W'($urandom));
            end
            sent += nq;
            if ($urandom_range(0, 5) == 0) begin
                stall_mode = $urandom_range(0, 1);
                gap_mode   = $urandom_range(0, 1);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_req_type    = REQ_WRITE;
        i_entry_index = '0;
        i_entry_freq  = '0;
        i_entry_param = '0;
        i_query_freq  = '0;
        error_count   = 0;
        stall_mode    = 0;
        gap_mode      = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_extremes();
        stall_mode = 1;
        gap_mode   = 1;
        test_zero_span();
        test_random(400);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_interp.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_calibration_linear_interpolator_unit passed");
        else
            $display("tb_calibration_linear_interpolator_unit failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20000000;
        $display("tb_calibration_linear_interpolator_unit failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/cli_pkg.sv
rtl/cli_div_pipe.sv
rtl/calibration_linear_interpolator_unit.sv
tb/tb_calibration_linear_interpolator_unit.sv
